>>> rtl/gpuf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpuf_pkg
// Shared types and fixed field widths of the percolation union-find block.
// ----------------------------------------------------------------------------
package gpuf_pkg;

  localparam int SIDE_W  = 6;
  localparam int COUNT_W = 11;

  typedef struct packed {
    logic              opcode;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
  } gpuf_in_t;

  typedef struct packed {
    logic               index_valid;
    logic               site_open;
    logic               site_full;
    logic               system_percolates;
    logic [COUNT_W-1:0] open_count;
  } gpuf_out_t;

  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

>>> rtl/gpuf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpuf_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gpuf_ram #(
  parameter int DEPTH = 1026,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

>>> rtl/grid_percolation_union_find.sv
`timescale 1ns / 1ps
// Sequence: decode the index and read the site; on an open, check each neighbor direction,
// and per open neighbor run two root walks and, if the roots differ, a weighted link; then
// two or three root walks (top, bottom, site) and load the result register. One transaction
// at a time: in_ready is high only while idle. Weighted linking keeps tree depth within
// log2(MAX_SIDE*MAX_SIDE+2). After reset or a grid_side write, a rebuild sweep blocks input
// and config.
// ----------------------------------------------------------------------------
// grid_percolation_union_find
// Percolation grid with a weighted union-find forest and virtual top/bottom.
// ----------------------------------------------------------------------------
module grid_percolation_union_find
  import gpuf_pkg::*;
#(
  parameter int MAX_SIDE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIDE_W-1:0] cfg_grid_side,
  input  logic              in_valid,
  output logic              in_ready,
  input  gpuf_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gpuf_out_t         out_data
);

  localparam int SITES = MAX_SIDE * MAX_SIDE;
  localparam int NODES = SITES + 2;
  localparam int NW    = $clog2(NODES);
  localparam int OW    = $clog2(SITES);
  localparam int WW    = $clog2(NODES + 1);
  localparam int SW    = $clog2(MAX_SIDE + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_PREP_B, S_CLEAR, S_CALC, S_OPEN_RD, S_OPEN_CHK,
    S_NB_SEL, S_NB_CHK, S_FIND_RD, S_FIND_CMP, S_WT_A, S_WT_B, S_WT_LINK,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {F_A, F_B, F_TOP, F_BOT, F_IDX} find_t;

  function automatic logic [SW-1:0] side_clamp(input logic [SIDE_W-1:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (w == 7'd0) begin
      side_clamp = SW'(1);
    end else if (w > 7'(MAX_SIDE)) begin
      side_clamp = SW'(MAX_SIDE);
    end else begin
      side_clamp = SW'(w);
    end
  endfunction

  state_t          state_r;
  find_t           fid_r;
  gpuf_in_t        in_r;
  logic [SW-1:0]   n_r;
  logic [NW-1:0]   nn_r;
  logic [NW-1:0]   bstart_r;
  logic [NW-1:0]   clr_r;
  logic [NW-1:0]   idx_r;
  logic [SIDE_W-1:0] r_r;
  logic [SIDE_W-1:0] c_r;
  logic            valid_r;
  logic            open_r;
  logic [2:0]      k_r;
  logic [NW-1:0]   nb_r;
  logic [NW-1:0]   cur_r;
  logic [NW-1:0]   a_r;
  logic [NW-1:0]   b_r;
  logic [NW-1:0]   rt_r;
  logic [NW-1:0]   rb_r;
  logic [NW-1:0]   ri_r;
  logic [WW-1:0]   wa_r;
  logic [COUNT_W-1:0] cnt_r;
  logic            out_valid_r;
  gpuf_out_t       out_data_r;

  // Memory ports
  logic          p_we, w_we, o_we;
  logic [NW-1:0] p_wa, p_wd, p_ra, p_rd, w_wa, w_ra;
  logic [WW-1:0] w_wd, w_rd;
  logic [OW-1:0] o_wa, o_ra;
  logic          o_wd, o_rd;

  gpuf_ram #(.DEPTH(NODES), .WIDTH(NW)) u_parent (
    .clk(clk), .we(p_we), .wa(p_wa), .wd(p_wd), .ra(p_ra), .rd(p_rd)
  );
  gpuf_ram #(.DEPTH(NODES), .WIDTH(WW)) u_weight (
    .clk(clk), .we(w_we), .wa(w_wa), .wd(w_wd), .ra(w_ra), .rd(w_rd)
  );
  gpuf_ram #(.DEPTH(SITES), .WIDTH(1)) u_open (
    .clk(clk), .we(o_we), .wa(o_wa), .wd(o_wd), .ra(o_ra), .rd(o_rd)
  );

  // Index and neighbor arithmetic
  logic          row_ok, col_ok;
  logic [SIDE_W-1:0] r_calc, c_calc;
  logic [13:0]   idx_calc;
  logic          nb_ok;
  logic [NW-1:0] nb_idx;
  logic          opening;
  logic [NW-1:0] sw_par;
  logic [WW-1:0] sw_wt;
  logic          a_light;

  always_comb begin
    row_ok   = (in_r.row != '0) && ({1'b0, in_r.row} <= 7'(n_r));
    col_ok   = (in_r.col != '0) && ({1'b0, in_r.col} <= 7'(n_r));
    r_calc   = in_r.row - SIDE_W'(1);
    c_calc   = in_r.col - SIDE_W'(1);
    idx_calc = 14'(r_calc) * 14'(n_r) + 14'(c_calc);
    opening  = (in_r.opcode == OP_OPEN) && !o_rd;
    a_light  = (wa_r < w_rd);
  end

  always_comb begin
    unique case (k_r[1:0])
      2'd0: begin
        nb_ok  = (r_r != '0);
        nb_idx = idx_r - NW'(n_r);
      end
      2'd1: begin
        nb_ok  = (7'(r_r) + 7'd1 < 7'(n_r));
        nb_idx = idx_r + NW'(n_r);
      end
      2'd2: begin
        nb_ok  = (c_r != '0);
        nb_idx = idx_r - NW'(1);
      end
      default: begin
        nb_ok  = (7'(c_r) + 7'd1 < 7'(n_r));
        nb_idx = idx_r + NW'(1);
      end
    endcase
  end

  // Rebuild values: top row under node 0, bottom row under its first site
  always_comb begin
    sw_par = clr_r;
    sw_wt  = WW'(1);
    priority if (clr_r == '0) begin
      sw_wt = WW'(n_r) + ((n_r == SW'(1)) ? WW'(2) : WW'(1));
    end else if (clr_r == bstart_r) begin
      sw_wt = WW'(n_r) + WW'(1);
    end else if (clr_r < NW'(n_r)) begin
      sw_par = '0;
    end else if (clr_r == nn_r) begin
      sw_par = '0;
    end else if (clr_r == nn_r + NW'(1)) begin
      sw_par = bstart_r;
    end else if (clr_r > bstart_r && clr_r < nn_r) begin
      sw_par = bstart_r;
    end else begin
      sw_par = clr_r;
    end
  end

  // Memory control
  always_comb begin
    p_ra = (state_r == S_FIND_CMP) ? p_rd : cur_r;
    w_ra = (state_r == S_WT_A) ? a_r : b_r;
    o_ra = (state_r == S_OPEN_RD) ? OW'(idx_r) : OW'(nb_idx);
    p_we = 1'b0;
    p_wa = clr_r;
    p_wd = sw_par;
    w_we = 1'b0;
    w_wa = clr_r;
    w_wd = sw_wt;
    o_we = 1'b0;
    o_wa = OW'(clr_r);
    o_wd = 1'b0;
    if (state_r == S_CLEAR) begin
      p_we = 1'b1;
      w_we = 1'b1;
      o_we = (32'(clr_r) < SITES);
    end else if (state_r == S_OPEN_CHK && opening) begin
      o_we = 1'b1;
      o_wa = OW'(idx_r);
      o_wd = 1'b1;
    end else if (state_r == S_WT_LINK) begin
      p_we = 1'b1;
      w_we = 1'b1;
      p_wa = a_light ? a_r : b_r;
      p_wd = a_light ? b_r : a_r;
      w_wa = a_light ? b_r : a_r;
      w_wd = WW'(wa_r + w_rd);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PREP;
      n_r         <= side_clamp(SIDE_W'(32));
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one loads now
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        // rebuild on a grid side write
        n_r     <= side_clamp(cfg_grid_side);
        state_r <= S_PREP;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_valid && in_ready) begin
              in_r    <= in_data;
              state_r <= S_CALC;
            end
          end
          S_PREP: begin
            nn_r    <= NW'(14'(n_r) * 14'(n_r));
            cnt_r   <= '0;
            clr_r   <= '0;
            state_r <= S_PREP_B;
          end
          S_PREP_B: begin
            bstart_r <= nn_r - NW'(n_r);
            state_r  <= S_CLEAR;
          end
          S_CLEAR: begin
            clr_r <= clr_r + NW'(1);
            if (32'(clr_r) == NODES - 1) begin
              state_r <= S_IDLE;
            end
          end
          S_CALC: begin
            valid_r <= row_ok && col_ok;
            r_r     <= r_calc;
            c_r     <= c_calc;
            idx_r   <= NW'(idx_calc);
            if (row_ok && col_ok) begin
              state_r <= S_OPEN_RD;
            end else begin
              open_r  <= 1'b0;
              cur_r   <= nn_r;
              fid_r   <= F_TOP;
              state_r <= S_FIND_RD;
            end
          end
          S_OPEN_RD: begin
            state_r <= S_OPEN_CHK;
          end
          S_OPEN_CHK: begin
            open_r <= o_rd || (in_r.opcode == OP_OPEN);
            if (opening) begin
              cnt_r   <= cnt_r + COUNT_W'(1);
              k_r     <= '0;
              state_r <= S_NB_SEL;
            end else begin
              cur_r   <= nn_r;
              fid_r   <= F_TOP;
              state_r <= S_FIND_RD;
            end
          end
          S_NB_SEL: begin
            if (k_r[2]) begin
              cur_r   <= nn_r;
              fid_r   <= F_TOP;
              state_r <= S_FIND_RD;
            end else if (nb_ok) begin
              nb_r    <= nb_idx;
              state_r <= S_NB_CHK;
            end else begin
              k_r <= k_r + 3'd1;
            end
          end
          S_NB_CHK: begin
            if (o_rd) begin
              cur_r   <= idx_r;
              fid_r   <= F_A;
              state_r <= S_FIND_RD;
            end else begin
              k_r     <= k_r + 3'd1;
              state_r <= S_NB_SEL;
            end
          end
          S_FIND_RD: begin
            state_r <= S_FIND_CMP;
          end
          S_FIND_CMP: begin
            if (p_rd != cur_r) begin
              // advance one level toward the root
              cur_r <= p_rd;
            end else begin
              unique case (fid_r)
                F_A: begin
                  a_r     <= cur_r;
                  cur_r   <= nb_r;
                  fid_r   <= F_B;
                  state_r <= S_FIND_RD;
                end
                F_B: begin
                  b_r <= cur_r;
                  if (cur_r == a_r) begin
                    k_r     <= k_r + 3'd1;
                    state_r <= S_NB_SEL;
                  end else begin
                    state_r <= S_WT_A;
                  end
                end
                F_TOP: begin
                  rt_r    <= cur_r;
                  cur_r   <= nn_r + NW'(1);
                  fid_r   <= F_BOT;
                  state_r <= S_FIND_RD;
                end
                F_BOT: begin
                  rb_r <= cur_r;
                  if (open_r) begin
                    cur_r   <= idx_r;
                    fid_r   <= F_IDX;
                    state_r <= S_FIND_RD;
                  end else begin
                    state_r <= S_DONE;
                  end
                end
                default: begin
                  ri_r    <= cur_r;
                  state_r <= S_DONE;
                end
              endcase
            end
          end
          S_WT_A: begin
            state_r <= S_WT_B;
          end
          S_WT_B: begin
            wa_r    <= w_rd;
            state_r <= S_WT_LINK;
          end
          S_WT_LINK: begin
            k_r     <= k_r + 3'd1;
            state_r <= S_NB_SEL;
          end
          S_DONE: begin
            if (!out_valid_r || out_ready) begin
              out_data_r.index_valid       <= valid_r;
              out_data_r.site_open         <= open_r;
              out_data_r.site_full         <= open_r && (ri_r == rt_r);
              out_data_r.system_percolates <= (rt_r == rb_r);
              out_data_r.open_count        <= cnt_r;
              out_valid_r                  <= 1'b1;
              state_r                      <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
